// File: hw/rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list: op and status codes,
// field widths and the command broadcast to the storage cells.
// ----------------------------------------------------------------------------
package bal_pkg;

   localparam int LIST_CAPACITY = 16;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 5;

   typedef enum logic [1:0] {
      OP_APPEND       = 2'd0,
      OP_REMOVE_SHIFT = 2'd1,
      OP_REMOVE_SWAP  = 2'd2,
      OP_READ         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   // command seen by every cell in the update cycle
   typedef struct packed {
      logic               apply;
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
   } bal_cmd_type;

endpackage

// File: hw/rtl/bal_req_if.sv
// ----------------------------------------------------------------------------
// bal_req_if
// Request channel: one beat carries an op, a value and a read position.
// ----------------------------------------------------------------------------
interface bal_req_if import bal_pkg::*; ();

   logic                      valid;
   logic                      ready;
   op_type                    op;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, op, value, position, input ready);
   modport sink   (input valid, op, value, position, output ready);

endinterface

// File: hw/rtl/bal_rsp_if.sv
// ----------------------------------------------------------------------------
// bal_rsp_if
// Response channel: one beat per request with status, read data and the
// list occupancy after the operation.
// ----------------------------------------------------------------------------
interface bal_rsp_if import bal_pkg::*; #(
   parameter int CNT_W = $clog2(LIST_CAPACITY + 1)
) ();

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   status_type                status;
   logic [CNT_W-1:0]          entry_count;
   logic                      is_full;
   logic                      is_empty;

   modport source (output valid, read_value, status, entry_count, is_full, is_empty,
                   input ready);
   modport sink   (input valid, read_value, status, entry_count, is_full, is_empty,
                   output ready);

endinterface

// File: hw/rtl/bal_cell.sv
// ----------------------------------------------------------------------------
// bal_cell
// One list slot. Compares its entry against the search value, passes the
// first-match flag and the read/last taps down the row, and takes a new
// entry from the request, its right neighbor or the last slot.
// ----------------------------------------------------------------------------
module bal_cell import bal_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic               clock,
   input  bal_cmd_type        cmd,
   input  logic [CNT_W-1:0]   count,
   input  logic               found_in,
   output logic               found_out,
   input  logic [VALUE_W-1:0] next_data,
   input  logic [VALUE_W-1:0] last_data,
   output logic [VALUE_W-1:0] data_out,
   input  logic [VALUE_W-1:0] rd_in,
   output logic [VALUE_W-1:0] rd_out,
   input  logic [VALUE_W-1:0] last_in,
   output logic [VALUE_W-1:0] last_out
);

   localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);
   localparam bit ReadReach = (IDX < (1 << POS_W));

   logic [VALUE_W-1:0] data_ff, data_in;
   logic               occupied, match, hit, is_last, rd_sel;

   // slot status and match
   assign occupied  = MyIdx < count;
   assign match     = occupied && (data_ff == cmd.value);
   assign hit       = match && !found_in;
   assign found_out = found_in || match;
   assign is_last   = (MyIdx == count - CNT_W'(1));

   // read tap: position is 1-based
   assign rd_sel   = ReadReach && (POS_W'(IDX) == cmd.pos - POS_W'(1));
   assign rd_out   = rd_in | (rd_sel ? data_ff : '0);
   assign last_out = last_in | (is_last ? data_ff : '0);
   assign data_out = data_ff;

   // next entry
   always_comb begin
      data_in = data_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            OP_APPEND: begin
               if (MyIdx == count) data_in = cmd.value;
            end
            OP_REMOVE_SHIFT: begin
               if (occupied && found_out) data_in = next_data;
            end
            OP_REMOVE_SWAP: begin
               if (hit) data_in = last_data;
            end
            default: data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: hw/rtl/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list
// Bounded list of signed 32-bit values kept in a row of storage cells.
// ----------------------------------------------------------------------------
// A request beat is first captured; then all cells compare against the value
// in parallel, the first-match flag ripples down the row of cells, and the
// list shifts, swaps, appends or is read while the response is registered.
// That ripple through the row sets the cycle time. A new request is taken in
// the cycle after the update, even while the previous response waits on
// rsp_bus; the update holds only while an earlier response is still untaken.
// Entry storage needs no clearing after reset.
module bounded_array_list import bal_pkg::*; #(
   parameter int CAPACITY = LIST_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   bal_req_if.sink      req_bus,
   bal_rsp_if.source    rsp_bus
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;
   localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);

   logic                busy_ff;
   op_type              op_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [CntW-1:0]     count_ff, count_in;

   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rd_value_ff, rd_value_in;
   status_type          status_ff, status_in;

   logic                apply, pos_ok, found;
   bal_cmd_type         cmd;

   logic [CAPACITY:0]   found_chain;
   logic [VALUE_W-1:0]  rd_chain   [CAPACITY+1];
   logic [VALUE_W-1:0]  last_chain [CAPACITY+1];
   logic [VALUE_W-1:0]  cell_data  [CAPACITY];

   // request capture
   assign req_bus.ready = !busy_ff;
   assign apply = busy_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         op_ff    <= req_bus.op;
         value_ff <= req_bus.value;
         pos_ff   <= req_bus.position;
      end
   end

   assign cmd.apply = apply;
   assign cmd.op    = op_ff;
   assign cmd.value = value_ff;
   assign cmd.pos   = pos_ff;

   // row of cells
   assign found_chain[0] = 1'b0;
   assign rd_chain[0]    = '0;
   assign last_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] nbr;
      if (i == CAPACITY - 1) begin : g_end
         assign nbr = cell_data[i];
      end else begin : g_mid
         assign nbr = cell_data[i+1];
      end
      bal_cell #(.IDX(i), .CNT_W(CntW)) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .found_in  (found_chain[i]),
         .found_out (found_chain[i+1]),
         .next_data (nbr),
         .last_data (last_chain[CAPACITY]),
         .data_out  (cell_data[i]),
         .rd_in     (rd_chain[i]),
         .rd_out    (rd_chain[i+1]),
         .last_in   (last_chain[i]),
         .last_out  (last_chain[i+1])
      );
   end

   assign found  = found_chain[CAPACITY];
   assign pos_ok = (pos_ff != '0) && (CmpW'(pos_ff) <= CmpW'(count_ff));

   // result and count update
   always_comb begin
      count_in    = count_ff;
      status_in   = ST_OK;
      rd_value_in = '0;
      unique case (op_ff)
         OP_APPEND: begin
            if (count_ff == CapCount) status_in = ST_FULL;
            else count_in = count_ff + CntW'(1);
         end
         OP_REMOVE_SHIFT, OP_REMOVE_SWAP: begin
            if (!found) status_in = ST_NOT_FOUND;
            else count_in = count_ff - CntW'(1);
         end
         OP_READ: begin
            if (!pos_ok) status_in = ST_BAD_POS;
            else rd_value_in = rd_chain[CAPACITY];
         end
         default: status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            busy_ff <= 1'b1;
         end else if (apply) begin
            busy_ff <= 1'b0;
         end
         if (apply) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         rd_value_ff <= rd_value_in;
         status_ff   <= status_in;
      end
   end

   // response beat
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = rd_value_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.entry_count = count_ff;
   assign rsp_bus.is_full     = (count_ff == CapCount);
   assign rsp_bus.is_empty    = (count_ff == '0);

endmodule

// File: hw/rtl/bal_checker.sv
// ----------------------------------------------------------------------------
// bal_checker
// Port-level checks on the bounded array list: response hold, flag
// consistency, zero read data on errors and one request in flight at a time.
// ----------------------------------------------------------------------------
module bal_checker import bal_pkg::*; #(
   parameter int CAPACITY = LIST_CAPACITY,
   parameter int CNT_W    = $clog2(LIST_CAPACITY + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_read_value,
   input status_type         rsp_status,
   input logic [CNT_W-1:0]   rsp_entry_count,
   input logic               rsp_is_full,
   input logic               rsp_is_empty
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("response beat changed while stalled");

   // flags follow the count
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_full == (rsp_entry_count == CNT_W'(CAPACITY)))
         && (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("full/empty flags disagree with entry count");

   // read data is zero on any error
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0)
      else $error("nonzero read value with error status");

   // one request in flight
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

endmodule

bind bounded_array_list bal_checker #(
   .CAPACITY (CAPACITY),
   .CNT_W    (CntW)
) u_bal_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_read_value  (rsp_bus.read_value),
   .rsp_status      (rsp_bus.status),
   .rsp_entry_count (rsp_bus.entry_count),
   .rsp_is_full     (rsp_bus.is_full),
   .rsp_is_empty    (rsp_bus.is_empty)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_array_list. A short table of directed
// requests covers the empty list, the full list, signed extremes, duplicate
// values, bad read positions and dropping the last entry with a swap. A long
// run of random requests follows, with the list pushed alternately toward
// full and toward empty. Every response beat is compared in order with the
// beat that its table row or a behavioral list model in this bench predicts.
// Valid and ready are throttled at random in three phases, the last with none.
// ----------------------------------------------------------------------------
module tb_top import bal_pkg::*; ();

   localparam int CNT_W       = $clog2(LIST_CAPACITY + 1);
   localparam int RAND_PHASE  = 237;
   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 8;

   // one response beat as the list should produce it
   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
      logic [CNT_W-1:0]          entry_count;
      logic                      is_full;
      logic                      is_empty;
   } list_rsp_type;

   // directed stimulus row; typed rows carry their own expected beat
   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic [4:0]         reps;
      logic               typed;
      list_rsp_type       rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   bal_req_if req_bus ();
   bal_rsp_if rsp_bus ();

   bounded_array_list u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // list model state
   logic [VALUE_W-1:0] list_vals [LIST_CAPACITY];
   int                 list_len = 0;

   list_rsp_type       rsp_expect_q [$];
   logic [VALUE_W-1:0] value_pool [8];
   int                 send_idle_pct = 0;
   int                 stall_pct     = 0;
   int                 errors        = 0;
   int                 quiet_cycles  = 0;

   dir_row_type dir_table [25] = '{
      '{OP_READ,         32'h0,        5'd0,  5'd1,  1'b1, '{32'h0, ST_BAD_POS,   5'd0, 1'b0, 1'b1}},
      '{OP_REMOVE_SHIFT, 32'h0,        5'd0,  5'd1,  1'b1, '{32'h0, ST_NOT_FOUND, 5'd0, 1'b0, 1'b1}},
      '{OP_REMOVE_SWAP,  32'h0,        5'd0,  5'd1,  1'b1, '{32'h0, ST_NOT_FOUND, 5'd0, 1'b0, 1'b1}},
      '{OP_READ,         32'h0,        5'd1,  5'd1,  1'b1, '{32'h0, ST_BAD_POS,   5'd0, 1'b0, 1'b1}},
      '{OP_APPEND,       32'h7FFFFFFF, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd1, 1'b0, 1'b0}},
      '{OP_APPEND,       32'h80000000, 5'd31, 5'd1,  1'b1, '{32'h0, ST_OK,        5'd2, 1'b0, 1'b0}},
      '{OP_APPEND,       32'hFFFFFFFF, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd3, 1'b0, 1'b0}},
      '{OP_APPEND,       32'h0,        5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd4, 1'b0, 1'b0}},
      '{OP_APPEND,       32'hFFFFFFFF, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd5, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd1,  5'd1,  1'b1,
        '{32'h7FFFFFFF, ST_OK, 5'd5, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd2,  5'd1,  1'b1,
        '{32'h80000000, ST_OK, 5'd5, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd31, 5'd1,  1'b1, '{32'h0, ST_BAD_POS,   5'd5, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd6,  5'd1,  1'b1, '{32'h0, ST_BAD_POS,   5'd5, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd5,  5'd1,  1'b0, '0},
      // duplicate: only the lower copy goes
      '{OP_REMOVE_SHIFT, 32'hFFFFFFFF, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd4, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd4,  5'd1,  1'b0, '0},
      '{OP_REMOVE_SWAP,  32'h7FFFFFFF, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd3, 1'b0, 1'b0}},
      '{OP_READ,         32'h0,        5'd1,  5'd1,  1'b0, '0},
      // swap removal of the last entry just drops it
      '{OP_REMOVE_SWAP,  32'h0,        5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,        5'd2, 1'b0, 1'b0}},
      '{OP_REMOVE_SHIFT, 32'h00003039, 5'd0,  5'd1,  1'b1, '{32'h0, ST_NOT_FOUND, 5'd2, 1'b0, 1'b0}},
      // fill up, then hit the full list
      '{OP_APPEND,       32'h5,        5'd0,  5'd14, 1'b0, '0},
      '{OP_APPEND,       32'h7,        5'd0,  5'd1,  1'b1, '{32'h0, ST_FULL,     5'd16, 1'b1, 1'b0}},
      '{OP_READ,         32'h0,        5'd17, 5'd1,  1'b1, '{32'h0, ST_BAD_POS,  5'd16, 1'b1, 1'b0}},
      '{OP_READ,         32'h0,        5'd16, 5'd1,  1'b0, '0},
      '{OP_REMOVE_SHIFT, 32'h80000000, 5'd0,  5'd1,  1'b1, '{32'h0, ST_OK,       5'd15, 1'b0, 1'b0}}
   };

   // apply one op to the list model and return the beat it should give
   function automatic list_rsp_type list_step(input op_type op,
                                              input logic [VALUE_W-1:0] value,
                                              input logic [POS_W-1:0] pos);
      list_rsp_type r;
      int           hit;
      r        = '0;
      r.status = ST_OK;
      case (op)
         OP_APPEND: begin
            if (list_len >= LIST_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_vals[list_len] = value;
               list_len++;
            end
         end
         OP_REMOVE_SHIFT, OP_REMOVE_SWAP: begin
            // lowest matching position wins
            hit = -1;
            for (int i = list_len - 1; i >= 0; i--)
               if (list_vals[i] == value) hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else if (op == OP_REMOVE_SHIFT) begin
               for (int i = hit; i < list_len - 1; i++)
                  list_vals[i] = list_vals[i + 1];
               list_len--;
            end else begin
               list_vals[hit] = list_vals[list_len - 1];
               list_len--;
            end
         end
         default: begin
            if (pos == 0 || pos > list_len) r.status = ST_BAD_POS;
            else r.read_value = list_vals[pos - 1];
         end
      endcase
      r.entry_count = list_len[CNT_W-1:0];
      r.is_full     = (list_len == LIST_CAPACITY);
      r.is_empty    = (list_len == 0);
      return r;
   endfunction

   // drive one request beat, hold it until taken, then queue its response
   task automatic send_req(input op_type op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos, input logic typed,
                           input list_rsp_type typed_rsp);
      list_rsp_type pred;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.value    <= value;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      pred = list_step(op, value, pos);
      rsp_expect_q.push_back(typed ? typed_rsp : pred);
   endtask

   // stimulus
   initial begin
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      int                 roll;
      logic               grow;
      grow             = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_APPEND;
      req_bus.value    = '0;
      req_bus.position = '0;
      foreach (value_pool[k]) value_pool[k] = $urandom;
      send_idle_pct = 11;
      stall_pct     = 74;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[k])
         repeat (dir_table[k].reps)
            send_req(dir_table[k].op, dir_table[k].value, dir_table[k].pos,
                     dir_table[k].typed, dir_table[k].rsp);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 74 : 0;
         stall_pct     = (ph == 0) ? 74 : (ph == 1) ? 11 : 0;
         for (int n = 0; n < RAND_PHASE; n++) begin
            // swing the list between filling and draining
            if ((n % 48) == 0) grow = ~grow;
            if ((n % 64) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 55 : 20)) op = OP_APPEND;
            else if (roll < (grow ? 80 : 75)) op = roll[0] ? OP_REMOVE_SHIFT : OP_REMOVE_SWAP;
            else op = OP_READ;
            // removes mostly target values that are present
            if (op != OP_APPEND && list_len > 0 && $urandom_range(0, 99) < 60)
               value = list_vals[$urandom_range(0, list_len - 1)];
            else if ($urandom_range(0, 1) == 1)
               value = value_pool[$urandom_range(0, 7)];
            else
               value = $urandom;
            if (list_len > 0 && $urandom_range(0, 3) != 0)
               pos = POS_W'($urandom_range(1, list_len));
            else
               pos = POS_W'($urandom_range(0, 31));
            send_req(op, value, pos, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // response side: check each taken beat, then pick ready for the next cycle
   initial begin
      list_rsp_type exp;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_expect_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errors++;
            end else begin
               exp = rsp_expect_q.pop_front();
               if (rsp_bus.read_value !== exp.read_value) begin
                  $error("read_value: expected %0d, got %0d", exp.read_value, rsp_bus.read_value);
                  errors++;
               end
               if (rsp_bus.status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.entry_count !== exp.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", exp.entry_count,
                         rsp_bus.entry_count);
                  errors++;
               end
               if (rsp_bus.is_full !== exp.is_full) begin
                  $error("is_full: expected %0d, got %0d", exp.is_full, rsp_bus.is_full);
                  errors++;
               end
               if (rsp_bus.is_empty !== exp.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", exp.is_empty, rsp_bus.is_empty);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog: no beat on either channel for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
